// ===== src/lvbd_pkg.sv =====
// shared constants, codes and types of the label volume boundary detector
package lvbd_pkg;

  // default volume limits and label width
  localparam int MAX_X_DEF      = 256;
  localparam int MAX_Y_DEF      = 256;
  localparam int MAX_Z_DEF      = 1024;
  localparam int LABEL_BITS_DEF = 32;

  // fixed field widths
  localparam int INDEX_W  = 26;
  localparam int LABEL_W  = 32;
  localparam int XCFG_W   = 9;
  localparam int YCFG_W   = 9;
  localparam int ZCFG_W   = 11;
  localparam int CIDX_W   = 2;
  localparam int CDATA_W  = 11;

  // input item kinds
  localparam logic OP_VOXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_X_SIZE = 2'd0,
    REG_Y_SIZE = 2'd1,
    REG_Z_SIZE = 2'd2
  } cfg_reg_t;

  // which face neighbours lie inside the volume
  typedef struct packed {
    logic xm;
    logic xp;
    logic ym;
    logic yp;
    logic zm;
    logic zp;
  } nbr_t;

  // command from the front part to the back part (one window shift)
  typedef struct packed {
    logic               emit;
    logic               last;
    nbr_t               nbr;
    logic [INDEX_W-1:0] index;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

endpackage

// ===== src/label_volume_boundary_detect.sv =====
// top level of the six-neighbour label boundary detector
//
// Voxel labels enter on the s_ channel in raster order (x fastest, then y,
// then z); s_tuser low selects a label, high a drain item. One result per
// decided voxel leaves on the m_ channel with its raster index, label,
// boundary flag (m_tuser) and last-voxel mark (m_tlast).
// A voxel is decided when the label one plane ahead of it arrives; after
// the final label, one drain item per pending voxel flushes the tail.
// Labels past the volume end and drains arriving before the final label are dropped.
// Throughput is one item per cycle while the output is not stalled. A
// result passes the queue write, the window shift and the output register
// in that order after the edge that accepts the item deciding it.
// The window is two plane delay memories and two row delay memories, each
// read and written once per window shift.
// Size writes on the cfg port also restart the volume counters.
// Reset clears the counters, sets sizes to their maxima, no memory clearing.
// When m_tready is low the result is held, one more voxel waits in the
// back part and the two-entry queue fills before s_tready drops.
module label_volume_boundary_detect #(
  parameter int MAX_X      = lvbd_pkg::MAX_X_DEF,
  parameter int MAX_Y      = lvbd_pkg::MAX_Y_DEF,
  parameter int MAX_Z      = lvbd_pkg::MAX_Z_DEF,
  parameter int LABEL_BITS = lvbd_pkg::LABEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lvbd_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [lvbd_pkg::CDATA_W-1:0]  cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [31:0]                   s_tdata,   // voxel_label
  input  logic                          s_tuser,   // opcode
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [63:0]                   m_tdata,   // voxel_index, label_out, zero pad
  output logic                          m_tuser,   // is_boundary
  output logic                          m_tlast    // is_last
);

  localparam int LW  = (LABEL_BITS < lvbd_pkg::LABEL_W) ? LABEL_BITS : lvbd_pkg::LABEL_W;
  localparam int XW  = $clog2(MAX_X + 1);
  localparam int YW  = $clog2(MAX_Y + 1);
  localparam int ZW  = $clog2(MAX_Z + 1);
  localparam int XEW = (XW > lvbd_pkg::XCFG_W) ? XW : lvbd_pkg::XCFG_W;
  localparam int YEW = (YW > lvbd_pkg::YCFG_W) ? YW : lvbd_pkg::YCFG_W;
  localparam int ZEW = (ZW > lvbd_pkg::ZCFG_W) ? ZW : lvbd_pkg::ZCFG_W;
  localparam int D1R = MAX_X * MAX_Y - MAX_X - 1;
  localparam int D1_DEPTH = (D1R > 1) ? D1R : 1;
  localparam int D2_DEPTH = (MAX_X - 2 > 1) ? MAX_X - 2 : 1;
  localparam int QW  = lvbd_pkg::CMD_W + LW;

  logic [lvbd_pkg::XCFG_W-1:0] x_size;
  logic [lvbd_pkg::YCFG_W-1:0] y_size;
  logic [lvbd_pkg::ZCFG_W-1:0] z_size;
  logic [XEW-1:0] x_ext;
  logic [YEW-1:0] y_ext;
  logic [ZEW-1:0] z_ext;
  logic [XW-1:0]  xc;
  logic [YW-1:0]  yc;
  logic [ZW-1:0]  zc;
  logic           clr;

  logic           q_push, q_ready, q_pop, q_valid;
  logic [QW-1:0]  q_in, q_out;

  logic [lvbd_pkg::INDEX_W-1:0] out_index;
  logic [LW-1:0]                out_label;

  // size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_size <= lvbd_pkg::XCFG_W'(256);
      y_size <= lvbd_pkg::YCFG_W'(256);
      z_size <= lvbd_pkg::ZCFG_W'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        lvbd_pkg::REG_X_SIZE: x_size <= cfg_data[lvbd_pkg::XCFG_W-1:0];
        lvbd_pkg::REG_Y_SIZE: y_size <= cfg_data[lvbd_pkg::YCFG_W-1:0];
        lvbd_pkg::REG_Z_SIZE: z_size <= cfg_data[lvbd_pkg::ZCFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      lvbd_pkg::REG_X_SIZE,
      lvbd_pkg::REG_Y_SIZE,
      lvbd_pkg::REG_Z_SIZE: clr = cfg_we;
      default:              clr = 1'b0;
    endcase
  end

  // sizes clamped to 1..MAX
  always_comb begin
    x_ext = XEW'(x_size);
    y_ext = YEW'(y_size);
    z_ext = ZEW'(z_size);
    if (x_ext == '0) x_ext = XEW'(1);
    else if (x_ext > XEW'(MAX_X)) x_ext = XEW'(MAX_X);
    if (y_ext == '0) y_ext = YEW'(1);
    else if (y_ext > YEW'(MAX_Y)) y_ext = YEW'(MAX_Y);
    if (z_ext == '0) z_ext = ZEW'(1);
    else if (z_ext > ZEW'(MAX_Z)) z_ext = ZEW'(MAX_Z);
  end

  assign xc = x_ext[XW-1:0];
  assign yc = y_ext[YW-1:0];
  assign zc = z_ext[ZW-1:0];

  lvbd_front #(.XW(XW), .YW(YW), .ZW(ZW), .LW(LW)) u_front (
    .clk(clk), .rst(rst), .clr(clr), .xc(xc), .yc(yc), .zc(zc),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_op(s_tuser),
    .in_label(s_tdata[LW-1:0]),
    .q_push(q_push), .q_ready(q_ready), .q_data(q_in)
  );

  lvbd_queue #(.W(QW)) u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_data(q_in), .push_ready(q_ready),
    .pop(q_pop), .pop_data(q_out), .pop_valid(q_valid)
  );

  lvbd_back #(
    .LW(LW), .XW(XW), .YW(YW), .D1_DEPTH(D1_DEPTH), .D2_DEPTH(D2_DEPTH)
  ) u_back (
    .clk(clk), .rst(rst), .clr(clr), .xc(xc), .yc(yc),
    .q_valid(q_valid), .q_data(q_out), .q_pop(q_pop),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_index(out_index), .out_label(out_label),
    .out_bnd(m_tuser), .out_last(m_tlast)
  );

  assign m_tdata = {6'd0, lvbd_pkg::LABEL_W'(out_label), out_index};

endmodule

// ===== src/lvbd_queue.sv =====
// two-entry queue between the front and back parts
module lvbd_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         push_ready,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         pop_valid
);

  logic [W-1:0] slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && push_ready) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && pop_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      if ((push && push_ready) && !(pop && pop_valid)) begin
        count <= count + 2'd1;
      end else if (!(push && push_ready) && (pop && pop_valid)) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== src/lvbd_front.sv =====
// front part: accepts items, tracks raster positions, issues shift commands
module lvbd_front #(
  parameter int XW = 9,
  parameter int YW = 9,
  parameter int ZW = 11,
  parameter int LW = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clr,
  input  logic [XW-1:0]               xc,
  input  logic [YW-1:0]               yc,
  input  logic [ZW-1:0]               zc,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [LW-1:0]               in_label,
  output logic                        q_push,
  input  logic                        q_ready,
  output logic [lvbd_pkg::CMD_W+LW-1:0] q_data
);

  logic [XW-1:0] rx, ex;
  logic [YW-1:0] ry, ey;
  logic [ZW-1:0] rz, ez;
  logic          all_rcvd;
  logic [lvbd_pkg::INDEX_W-1:0] eidx;

  logic acc, do_label, do_drain, emit;
  logic r_end, e_end, ex_end, ey_end, ez_end, rx_end, ry_end;
  lvbd_pkg::cmd_t cmd;

  assign in_ready = q_ready;
  assign acc      = in_valid && q_ready;

  // classify the item
  assign do_label = acc && (in_op == lvbd_pkg::OP_VOXEL) && !all_rcvd;
  assign do_drain = acc && (in_op == lvbd_pkg::OP_DRAIN) && all_rcvd;
  assign emit     = (do_label && (rz != '0)) || do_drain;

  assign rx_end = (rx == xc - XW'(1));
  assign ry_end = (ry == yc - YW'(1));
  assign r_end  = rx_end && ry_end && (rz == zc - ZW'(1));
  assign ex_end = (ex == xc - XW'(1));
  assign ey_end = (ey == yc - YW'(1));
  assign ez_end = (ez == zc - ZW'(1));
  assign e_end  = ex_end && ey_end && ez_end;

  // command for the back part
  always_comb begin
    cmd.emit    = emit;
    cmd.last    = e_end;
    cmd.nbr.xm  = (ex != '0);
    cmd.nbr.xp  = !ex_end;
    cmd.nbr.ym  = (ey != '0);
    cmd.nbr.yp  = !ey_end;
    cmd.nbr.zm  = (ez != '0);
    cmd.nbr.zp  = !ez_end;
    cmd.index   = eidx;
  end

  assign q_push = do_label || do_drain;
  assign q_data = {in_label, cmd};

  // receive and emit position counters
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      rx       <= '0;
      ry       <= '0;
      rz       <= '0;
      all_rcvd <= 1'b0;
      ex       <= '0;
      ey       <= '0;
      ez       <= '0;
      eidx     <= '0;
    end else begin
      if (do_label) begin
        rx <= rx_end ? '0 : rx + XW'(1);
        if (rx_end) begin
          ry <= ry_end ? '0 : ry + YW'(1);
          if (ry_end) begin
            rz <= rz + ZW'(1);
          end
        end
        if (r_end) begin
          all_rcvd <= 1'b1;
        end
      end
      if (emit) begin
        if (e_end) begin
          rx       <= '0;
          ry       <= '0;
          rz       <= '0;
          all_rcvd <= 1'b0;
          ex       <= '0;
          ey       <= '0;
          ez       <= '0;
          eidx     <= '0;
        end else begin
          eidx <= eidx + lvbd_pkg::INDEX_W'(1);
          ex   <= ex_end ? '0 : ex + XW'(1);
          if (ex_end) begin
            ey <= ey_end ? '0 : ey + YW'(1);
            if (ey_end) begin
              ez <= ez + ZW'(1);
            end
          end
        end
      end
    end
  end

endmodule

// ===== src/lvbd_delay.sv =====
// variable-length delay stage of the label window, ring memory plus taps
module lvbd_delay #(
  parameter int LW    = 32,
  parameter int LENW  = 16,
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            clr,
  input  logic            shift,
  input  logic [LENW-1:0] len,
  input  logic [LW-1:0]   din,
  output logic [LW-1:0]   dout
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [LW-1:0] mem [DEPTH];
  logic [LW-1:0] rd_data;
  logic [LW-1:0] one_reg;
  logic [AW-1:0] ptr;
  logic [LENW:0] ptr_inc;
  logic          wrap;

  // zero length passes through, length one is a single register
  assign dout = (len == '0) ? din : ((len == LENW'(1)) ? one_reg : rd_data);

  // pointer parks at zero when the stage is bypassed
  assign ptr_inc = (LENW+1)'(ptr) + (LENW+1)'(1);
  assign wrap    = (len == '0) || (ptr_inc >= ({1'b0, len} - (LENW+1)'(1)));

  // ring memory with registered read
  always_ff @(posedge clk) begin
    if (shift) begin
      mem[ptr] <= din;
      rd_data  <= mem[ptr];
      one_reg  <= din;
    end
  end

  // ring pointer
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      ptr <= '0;
    end else if (shift) begin
      ptr <= wrap ? '0 : AW'(ptr_inc);
    end
  end

endmodule

// ===== src/lvbd_back.sv =====
// back part: shifts the label window, compares neighbours, holds the result
module lvbd_back #(
  parameter int LW        = 32,
  parameter int XW        = 9,
  parameter int YW        = 9,
  parameter int D1_DEPTH  = 2,
  parameter int D2_DEPTH  = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clr,
  input  logic [XW-1:0]                 xc,
  input  logic [YW-1:0]                 yc,
  input  logic                          q_valid,
  input  logic [lvbd_pkg::CMD_W+LW-1:0] q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lvbd_pkg::INDEX_W-1:0]  out_index,
  output logic [LW-1:0]                 out_label,
  output logic                          out_bnd,
  output logic                          out_last
);

  localparam int PW = XW + YW;

  lvbd_pkg::cmd_t cmd, meta;
  logic [LW-1:0]  q_label;
  logic           meta_v;
  logic           out_free;
  logic [PW-1:0]  len_plane;
  logic [XW-1:0]  len_row;
  logic [LW-1:0]  t_zp, t_yp, t_xp, t_c, t_xm, t_ym, t_zm;
  logic           bnd;

  assign cmd     = q_data[lvbd_pkg::CMD_W-1:0];
  assign q_label = q_data[lvbd_pkg::CMD_W+LW-1:lvbd_pkg::CMD_W];

  assign out_free = !out_valid || out_ready;
  assign q_pop    = q_valid && (!meta_v || out_free);

  // delay lengths: one plane less one row, and one row less one voxel
  always_ff @(posedge clk) begin
    len_plane <= PW'(xc * (yc - YW'(1)));
  end
  assign len_row = xc - XW'(1);

  // window head and single-voxel taps
  always_ff @(posedge clk) begin
    if (q_pop) begin
      t_zp <= q_label;
      t_c  <= t_xp;
      t_xm <= t_c;
    end
  end

  lvbd_delay #(.LW(LW), .LENW(PW), .DEPTH(D1_DEPTH)) u_dly_fwd_plane (
    .clk(clk), .rst(rst), .clr(clr), .shift(q_pop), .len(len_plane),
    .din(t_zp), .dout(t_yp)
  );

  lvbd_delay #(.LW(LW), .LENW(XW), .DEPTH(D2_DEPTH)) u_dly_fwd_row (
    .clk(clk), .rst(rst), .clr(clr), .shift(q_pop), .len(len_row),
    .din(t_yp), .dout(t_xp)
  );

  lvbd_delay #(.LW(LW), .LENW(XW), .DEPTH(D2_DEPTH)) u_dly_back_row (
    .clk(clk), .rst(rst), .clr(clr), .shift(q_pop), .len(len_row),
    .din(t_xm), .dout(t_ym)
  );

  lvbd_delay #(.LW(LW), .LENW(PW), .DEPTH(D1_DEPTH)) u_dly_back_plane (
    .clk(clk), .rst(rst), .clr(clr), .shift(q_pop), .len(len_plane),
    .din(t_ym), .dout(t_zm)
  );

  // neighbour compare on the settled taps
  assign bnd = (meta.nbr.xm && (t_xm != t_c)) || (meta.nbr.xp && (t_xp != t_c)) ||
               (meta.nbr.ym && (t_ym != t_c)) || (meta.nbr.yp && (t_yp != t_c)) ||
               (meta.nbr.zm && (t_zm != t_c)) || (meta.nbr.zp && (t_zp != t_c));

  // command held while its taps settle
  always_ff @(posedge clk) begin
    if (q_pop) begin
      meta <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_v <= 1'b0;
    end else if (q_pop) begin
      meta_v <= cmd.emit;
    end else if (meta_v && out_free) begin
      meta_v <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (meta_v && out_free) begin
      out_index <= meta.index;
      out_label <= t_c;
      out_bnd   <= bnd;
      out_last  <= meta.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= meta_v;
    end
  end

`ifndef ASSERT_OFF
  a_pop_has_cmd: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("pop from empty queue");

  a_meta_held: assert property (@(posedge clk) disable iff (rst)
    (meta_v && !out_free) |=> (meta_v && $stable(t_c) && $stable(t_zp)))
    else $error("window moved under a pending result");

  a_meta_moves: assert property (@(posedge clk) disable iff (rst)
    (meta_v && out_free) |=> out_valid) else $error("decided voxel lost");

  a_no_pop_stalled: assert property (@(posedge clk) disable iff (rst)
    (meta_v && out_valid && !out_ready) |-> !q_pop)
    else $error("window shifted while result stalled");
`endif

endmodule

// ===== tb/lvbd_checker.sv =====
// checker for the label volume boundary detector: predicts decided voxels and compares
module lvbd_checker
  import lvbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [31:0]        s_tdata,
  input  logic               s_tuser,
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [63:0]        m_tdata,
  input  logic               m_tuser,
  input  logic               m_tlast,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [INDEX_W-1:0] index;
    logic [LABEL_W-1:0] label;
    logic               boundary;
    logic               last;
  } voxel_verdict_t;

  voxel_verdict_t verdict_queue[$];
  logic [LABEL_W-1:0] volume_labels[int unsigned];
  int unsigned labels_taken, voxels_decided;
  logic [XCFG_W-1:0] x_reg;
  logic [YCFG_W-1:0] y_reg;
  logic [ZCFG_W-1:0] z_reg;

  initial fail_count = 0;
  assign pending = verdict_queue.size();

  function automatic int unsigned eff_size(int unsigned v, int unsigned max);
    if (v == 0) return 1;
    if (v > max) return max;
    return v;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // decide the oldest undecided voxel from its six face neighbours
  task automatic decide_voxel();
    int unsigned nx, ny, nz, plane, e, x, y, z;
    logic [LABEL_W-1:0] lab;
    voxel_verdict_t v;
    nx = eff_size(x_reg, MAX_X_DEF);
    ny = eff_size(y_reg, MAX_Y_DEF);
    nz = eff_size(z_reg, MAX_Z_DEF);
    plane = nx * ny;
    e = voxels_decided;
    x = e % nx;
    y = (e / nx) % ny;
    z = e / plane;
    lab = volume_labels[e];
    v.boundary = 1'b0;
    if (x > 0 && volume_labels[e-1] != lab) v.boundary = 1'b1;
    if (y > 0 && volume_labels[e-nx] != lab) v.boundary = 1'b1;
    if (z > 0 && volume_labels[e-plane] != lab) v.boundary = 1'b1;
    if (x + 1 < nx && volume_labels[e+1] != lab) v.boundary = 1'b1;
    if (y + 1 < ny && volume_labels[e+nx] != lab) v.boundary = 1'b1;
    if (z + 1 < nz && volume_labels[e+plane] != lab) v.boundary = 1'b1;
    v.index = e[INDEX_W-1:0];
    v.label = lab;
    v.last = (e + 1 == plane * nz);
    verdict_queue = {verdict_queue, v};
    if (v.last) begin
      labels_taken = 0;
      voxels_decided = 0;
      volume_labels.delete();
    end else begin
      voxels_decided = e + 1;
    end
  endtask

  // track size writes and input transactions
  always @(posedge clk) begin
    int unsigned total, plane;
    if (rst) begin
      x_reg <= XCFG_W'(MAX_X_DEF);
      y_reg <= YCFG_W'(MAX_Y_DEF);
      z_reg <= ZCFG_W'(MAX_Z_DEF);
      labels_taken = 0;
      voxels_decided = 0;
      volume_labels.delete();
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_X_SIZE: x_reg <= cfg_data[XCFG_W-1:0];
        REG_Y_SIZE: y_reg <= cfg_data[YCFG_W-1:0];
        REG_Z_SIZE: z_reg <= cfg_data[ZCFG_W-1:0];
        default: ;
      endcase
      if (cfg_index <= REG_Z_SIZE) begin
        labels_taken = 0;
        voxels_decided = 0;
        volume_labels.delete();
      end
    end else if (s_tvalid && s_tready) begin
      plane = eff_size(x_reg, MAX_X_DEF) * eff_size(y_reg, MAX_Y_DEF);
      total = plane * eff_size(z_reg, MAX_Z_DEF);
      if (s_tuser == OP_VOXEL) begin
        if (labels_taken < total) begin
          volume_labels[labels_taken] = s_tdata;
          labels_taken++;
          if (labels_taken - voxels_decided > plane) decide_voxel();
        end
      end else if (labels_taken == total && voxels_decided < labels_taken) begin
        decide_voxel();
      end
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    voxel_verdict_t v;
    if (!rst && m_tvalid && m_tready) begin
      if (verdict_queue.size() == 0) begin
        report("unexpected result, index", m_tdata[INDEX_W-1:0], 0);
      end else begin
        v = verdict_queue.pop_front();
        if (m_tdata[INDEX_W-1:0] != v.index) report("voxel_index", m_tdata[25:0], v.index);
        if (m_tdata[57:26] != v.label) report("label_out", m_tdata[57:26], v.label);
        if (m_tdata[63:58] != 0) report("tdata pad", m_tdata[63:58], 0);
        if (m_tuser != v.boundary) report("is_boundary", m_tuser, v.boundary);
        if (m_tlast != v.last) report("is_last", m_tlast, v.last);
      end
    end
  end
endmodule

// ===== tb/tb.sv =====
// testbench top: stimulus for the label volume boundary detector and the verdict
module tb;
  import lvbd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1500000;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CDATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 0, s_tuser = 0, m_tready = 0;
  logic [31:0] s_tdata = '0;
  logic s_tready, m_tvalid, m_tuser, m_tlast;
  logic [63:0] m_tdata;
  int fail_count, pending;
  int send_idle = 0, recv_idle = 0;
  int hold_seq = 0, items_sent = 0, cycles = 0;
  logic [31:0] palette[3];

  label_volume_boundary_detect dut (.*);
  lvbd_checker checker_i (.*);

  initial forever #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    static int hold_cnt = 0, seen_seq = 0;
    if (hold_seq != seen_seq) begin
      seen_seq = hold_seq;
      hold_cnt = 400;
    end
    if (rst) m_tready <= 1'b0;
    else if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else m_tready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send(logic op, logic [31:0] lab);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= lab;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // wait until every predicted result has arrived and the pipeline is quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_sizes(int x, int y, int z);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= REG_X_SIZE;
    cfg_data <= CDATA_W'(x);
    @(posedge clk);
    cfg_index <= REG_Y_SIZE;
    cfg_data <= CDATA_W'(y);
    @(posedge clk);
    cfg_index <= REG_Z_SIZE;
    cfg_data <= CDATA_W'(z);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int eff(int v, int max);
    return (v == 0) ? 1 : (v > max) ? max : v;
  endfunction

  function automatic logic [31:0] pick_label();
    if ($urandom_range(7) == 0) return $urandom();
    return palette[$urandom_range(2)];
  endfunction

  // one volume of labels and drains; noisy volumes add ignored items
  task automatic run_volume(int x, int y, int z, bit noisy);
    int plane, total;
    plane = eff(x, MAX_X_DEF) * eff(y, MAX_Y_DEF);
    total = plane * eff(z, MAX_Z_DEF);
    palette[0] = $urandom();
    palette[1] = $urandom();
    palette[2] = $urandom_range(1) ? palette[0] : ~palette[1];
    for (int i = 0; i < total; i++) begin
      send(OP_VOXEL, pick_label());
      if (noisy && $urandom_range(15) == 0) send(OP_DRAIN, $urandom());
    end
    if (noisy) send(OP_VOXEL, $urandom());
    for (int i = 0; i < plane; i++) send(OP_DRAIN, $urandom());
    if (noisy) send(OP_DRAIN, $urandom());
  endtask

  task automatic random_volume();
    int x, y, z;
    case ($urandom_range(19))
      0: begin x = 256; y = 2; z = 1; end
      1: begin x = 1; y = 256; z = $urandom_range(1, 2); end
      2: begin x = $urandom_range(257, 511); y = 1; z = 1; end
      default: begin
        x = $urandom_range(0, 9);
        y = $urandom_range(0, 9);
        z = $urandom_range(0, 9);
      end
    endcase
    write_sizes(x, y, z);
    run_volume(x, y, z, $urandom_range(3) == 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero sizes act as one, single-voxel volume, extreme labels
    write_sizes(0, 0, 0);
    send(OP_DRAIN, 32'h0);             // drain too early
    send(OP_VOXEL, 32'hFFFF_FFFF);
    send(OP_VOXEL, 32'h0);             // label after volume end
    send(OP_DRAIN, 32'h0);
    send(OP_DRAIN, 32'hFFFF_FFFF);     // nothing pending
    // 2x2x2 with one odd voxel
    write_sizes(2, 2, 2);
    for (int i = 0; i < 8; i++) send(OP_VOXEL, (i == 5) ? 32'h0 : 32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) send(OP_DRAIN, 32'h0);
    // size write mid-volume discards pending voxels
    write_sizes(3, 1, 2);
    for (int i = 0; i < 4; i++) send(OP_VOXEL, 32'h5A5A_0000 + i);
    write_sizes(2, 1, 1);
    send(OP_VOXEL, 32'h1);
    send(OP_VOXEL, 32'h1);
    send(OP_DRAIN, 32'h0);
    send(OP_DRAIN, 32'h0);

    // deepest z, z size above its maximum
    write_sizes(1, 1, 2047);
    run_volume(1, 1, 2047, 0);

    // random volumes under three idle mixes
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 12 : (phase == 1) ? 49 : 0;
      recv_idle = (phase == 0) ? 49 : (phase == 1) ? 12 : 0;
      hold_seq++;
      while (items_sent < 300 * (phase + 1) + 1100) random_volume();
    end

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
src/lvbd_pkg.sv
src/lvbd_queue.sv
src/lvbd_front.sv
src/lvbd_delay.sv
src/lvbd_back.sv
src/label_volume_boundary_detect.sv
tb/lvbd_checker.sv
tb/tb.sv
